>>> hw/rtl/antialiased_steep_line_raster_assert.svh
// Assertion macros shared by the checker of the line rasteriser.
`ifndef ANTIALIASED_STEEP_LINE_RASTER_ASSERT_SVH
`define ANTIALIASED_STEEP_LINE_RASTER_ASSERT_SVH

// Same-cycle implication, masked while reset is held.
`define ASLR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("aslr: same-cycle check failed");

// Next-cycle implication, masked while reset is held.
`define ASLR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("aslr: next-cycle check failed");

// Next-cycle implication that also covers reset itself.
`define ASLR_ASSERT_RST(label, ante, cons) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("aslr: reset check failed");

`endif

>>> hw/rtl/aslr_pkg.sv
`default_nettype none

package aslr_pkg;

    // Fixed-point formats
    localparam int COORD_FRAC_BITS = 4;
    localparam int SLOPE_FRAC_BITS = 16;

    // Field widths
    localparam int COORD_W   = 16;
    localparam int CFG_W     = 12;
    localparam int CFG_IDX_W = 1;
    localparam int PIX_W     = 12;
    localparam int INT_W     = 8;
    localparam int ACC_W     = 32;

    // Derived widths
    localparam int DIVQ_W    = (COORD_W + SLOPE_FRAC_BITS > ACC_W) ?
                               (COORD_W + SLOPE_FRAC_BITS) : ACC_W;
    localparam int DIV_CNT_W = $clog2(DIVQ_W);
    localparam int ROW_W     = COORD_W + 2 - COORD_FRAC_BITS;
    localparam int IP_W      = ACC_W - SLOPE_FRAC_BITS;
    localparam int PROD_W    = SLOPE_FRAC_BITS + INT_W;
    localparam int ACC_SH    = SLOPE_FRAC_BITS - COORD_FRAC_BITS;
    localparam int ROUND_HALF = (1 << COORD_FRAC_BITS) >> 1;

    localparam int IN_TDATA_W  = 6 * COORD_W;
    localparam int OUT_TDATA_W = 2 * PIX_W + INT_W;

    // Constants
    localparam logic [ACC_W-1:0] SLOPE_MAX  = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic [INT_W-1:0] INT_FULL   = '1;
    localparam logic [CFG_W-1:0] WIDTH_RST  = 12'd1024;
    localparam logic [CFG_W-1:0] HEIGHT_RST = 12'd768;

    // Request kinds (tuser of the input stream)
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_STEP = 1'b1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = CFG_IDX_W'(1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_SLOPE,
        S_START,
        S_SPLIT,
        S_PIX0,
        S_PIX1,
        S_FINAL
    } t_state;

    // Fixed-point coordinate to integer, half away from zero
    function automatic logic signed [ROW_W-1:0] round_coord(
        input logic signed [COORD_W-1:0] v
    );
        logic [COORD_W:0] mag;
        logic [COORD_W:0] sum;
        logic [ROW_W-1:0] r;
        mag = v[COORD_W-1] ? (~{v[COORD_W-1], v} + (COORD_W+1)'(1)) : {1'b0, v};
        sum = mag + (COORD_W+1)'(ROUND_HALF);
        r   = ROW_W'(sum >> COORD_FRAC_BITS);
        return v[COORD_W-1] ? (~r + ROW_W'(1)) : r;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/aslr_div.sv
`default_nettype none

// Restoring divider: one quotient bit per cycle through a single subtractor
module aslr_div import aslr_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [DIVQ_W-1:0] i_dividend,
    input  wire logic [COORD_W-1:0] i_divisor,
    output logic                   o_done,
    output logic [DIVQ_W-1:0]      o_quot
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [COORD_W-1:0]   r_rem;
    logic [COORD_W-1:0]   r_div;
    logic [DIVQ_W-1:0]    r_quot;

    logic [COORD_W:0]     rem_sh;
    logic [COORD_W+1:0]   diff;
    logic                 fits;

    // Trial subtract of the shifted partial remainder
    always_comb begin
        rem_sh = {r_rem, r_quot[DIVQ_W-1]};
        diff   = {1'b0, rem_sh} - {2'b00, r_div};
        fits   = !diff[COORD_W+1];
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(DIVQ_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath, quotient bits shift in where dividend bits leave
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_div  <= i_divisor;
        end else if (r_busy) begin
            r_rem  <= fits ? diff[COORD_W-1:0] : rem_sh[COORD_W-1:0];
            r_quot <= {r_quot[DIVQ_W-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

`default_nettype wire

>>> hw/rtl/antialiased_steep_line_raster.sv
`default_nettype none

// Channel   | Dir | Handshake               | Content
// ----------+-----+-------------------------+---------------------------------
// s_axis    | in  | s_axis_tvalid/tready    | tdata: segment, tuser: req_type
// m_axis    | out | m_axis_tvalid/tready    | tdata: pixel, tuser: line_done
// cfg       | in  | i_cfg_valid/o_cfg_ready | index 0 screen_width, 1 height
//
// A load item waits on the bit-serial divider (one quotient bit per cycle, then done),
// then forms the slope, emits the start pixel and goes idle; a zero rise skips the
// divider. A step item splits the column, emits one beat per pixel and goes idle;
// a step with no segment loaded is taken and dropped.
// Synchronous active-low reset; config regs reset to 1024 x 768.
// A result beat waits in the output register; the block stalls on it only
// when it has the next beat ready. Input is taken only in the idle state.
module antialiased_steep_line_raster import aslr_pkg::*; (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // beats in
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // start_x, start_y, end_x, end_y, run_extent, rise_extent (from bit 0)
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // req_type
    input  wire logic                   s_axis_tuser,
    // beats out
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // pixel_x, pixel_y, intensity (from bit 0)
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
    // line_done
    output logic                        m_axis_tuser,
    output logic                        m_axis_tlast,
    // config writes
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [CFG_W-1:0]       i_cfg_data
);

    t_state r_state, n_state;

    // Config registers
    logic [CFG_W-1:0] r_width, r_height;

    // Segment state
    logic                       r_active;
    logic signed [COORD_W-1:0]  r_sx, r_sy, r_ex, r_ey;
    logic                       r_neg;
    logic                       r_rise_zero;
    logic [ACC_W-1:0]           r_slope;
    logic [ACC_W-1:0]           r_acc;
    logic signed [ROW_W-1:0]    r_row;

    // Split results of one row
    logic [PIX_W-1:0] r_px0, r_px1, r_py;
    logic [INT_W-1:0] r_lo, r_hi;
    logic             r_ok1;

    // Output register
    logic             r_out_valid;
    logic [PIX_W-1:0] r_out_px, r_out_py;
    logic [INT_W-1:0] r_out_int;
    logic             r_out_done, r_out_last;

    // Divider
    logic              div_start, div_done;
    logic [DIVQ_W-1:0] div_quot;

    // Handshake terms
    logic in_acc, out_free;

    // Input unpacking and endpoint swap
    logic signed [COORD_W-1:0] in_sx, in_sy, in_ex, in_ey;
    logic [COORD_W-1:0]        in_run, in_rise;
    logic                      in_swap;
    logic signed [COORD_W-1:0] sw_sx, sw_sy, sw_ex, sw_ey;

    // Row split
    logic signed [IP_W-1:0]            ip;
    logic signed [IP_W:0]              ip1;
    logic [SLOPE_FRAC_BITS-1:0]        frac;
    logic [PROD_W-1:0]                 prod;
    logic [INT_W-1:0]                  ceil_v;
    logic signed [ROW_W+COORD_FRAC_BITS-1:0] row_sc;
    logic                              below, row_ok, ok0, ok1;
    logic signed [CFG_W:0]             lim_w, lim_h;

    // Slope saturation
    logic [ACC_W-1:0] slope_mag;

    // Beat to emit
    logic             emit;
    logic [PIX_W-1:0] e_px, e_py;
    logic [INT_W-1:0] e_int;
    logic             e_done, e_last;

    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_out_valid || m_axis_tready;

    always_comb begin
        in_sx   = s_axis_tdata[0*COORD_W +: COORD_W];
        in_sy   = s_axis_tdata[1*COORD_W +: COORD_W];
        in_ex   = s_axis_tdata[2*COORD_W +: COORD_W];
        in_ey   = s_axis_tdata[3*COORD_W +: COORD_W];
        in_run  = s_axis_tdata[4*COORD_W +: COORD_W];
        in_rise = s_axis_tdata[5*COORD_W +: COORD_W];
        in_swap = in_ey < in_sy;
        sw_sx   = in_swap ? in_ex : in_sx;
        sw_sy   = in_swap ? in_ey : in_sy;
        sw_ex   = in_swap ? in_sx : in_ex;
        sw_ey   = in_swap ? in_sy : in_ey;
    end

    aslr_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (DIVQ_W'(in_run) << SLOPE_FRAC_BITS),
        .i_divisor  (in_rise),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    // Slope magnitude, saturated on zero rise or overflow
    always_comb begin
        if (r_rise_zero || (|div_quot[DIVQ_W-1:ACC_W-1]))
            slope_mag = SLOPE_MAX;
        else
            slope_mag = ACC_W'(div_quot);
    end

    // Column split of the accumulator, bounds and row test
    always_comb begin
        ip     = r_acc[ACC_W-1:SLOPE_FRAC_BITS];
        ip1    = (IP_W+1)'(ip) + (IP_W+1)'(1);
        frac   = r_acc[SLOPE_FRAC_BITS-1:0];
        prod   = (PROD_W'(frac) << INT_W) - PROD_W'(frac);
        ceil_v = prod[PROD_W-1:SLOPE_FRAC_BITS]
               + INT_W'(|prod[SLOPE_FRAC_BITS-1:0]);
        row_sc = (ROW_W+COORD_FRAC_BITS)'(r_row) <<< COORD_FRAC_BITS;
        below  = row_sc < r_ey;
        lim_w  = $signed({1'b0, r_width});
        lim_h  = $signed({1'b0, r_height});
        row_ok = (r_row >= 0) && (r_row <= lim_h);
        ok0    = row_ok && (ip >= 0) && (ip <= lim_w);
        ok1    = row_ok && (ip1 >= 0) && (ip1 <= lim_w);
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (s_axis_tuser == REQ_LOAD)
                        n_state = S_DIV;
                    else if (r_active)
                        n_state = S_SPLIT;
                end
            end
            S_DIV: begin
                if (r_rise_zero || div_done)
                    n_state = S_SLOPE;
            end
            S_SLOPE: n_state = S_START;
            S_START: begin
                if (out_free)
                    n_state = S_IDLE;
            end
            S_SPLIT: begin
                if (!below)
                    n_state = S_FINAL;
                else if (ok0)
                    n_state = S_PIX0;
                else if (ok1)
                    n_state = S_PIX1;
                else
                    n_state = S_IDLE;
            end
            S_PIX0: begin
                if (out_free)
                    n_state = r_ok1 ? S_PIX1 : S_IDLE;
            end
            S_PIX1: begin
                if (out_free)
                    n_state = S_IDLE;
            end
            S_FINAL: begin
                if (out_free)
                    n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb begin
        s_axis_tready = 1'b0;
        div_start     = 1'b0;
        emit          = 1'b0;
        e_px          = r_px0;
        e_py          = r_py;
        e_int         = INT_FULL;
        e_done        = 1'b0;
        e_last        = 1'b1;
        case (r_state)
            S_IDLE: begin
                s_axis_tready = 1'b1;
                div_start     = in_acc && (s_axis_tuser == REQ_LOAD) && (|in_rise);
            end
            S_START: begin
                emit = out_free;
                e_px = PIX_W'(round_coord(r_sx));
                e_py = PIX_W'(round_coord(r_sy));
            end
            S_PIX0: begin
                emit   = out_free;
                e_int  = r_hi;
                e_last = !r_ok1;
            end
            S_PIX1: begin
                emit  = out_free;
                e_px  = r_px1;
                e_int = r_lo;
            end
            S_FINAL: begin
                emit   = out_free;
                e_px   = PIX_W'(round_coord(r_ex));
                e_py   = PIX_W'(round_coord(r_ey));
                e_done = 1'b1;
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
            r_width     <= WIDTH_RST;
            r_height    <= HEIGHT_RST;
        end else begin
            r_state <= n_state;
            if (emit)
                r_out_valid <= 1'b1;
            else if (m_axis_tready)
                r_out_valid <= 1'b0;
            if (r_state == S_START && out_free)
                r_active <= 1'b1;
            else if (r_state == S_FINAL && out_free)
                r_active <= 1'b0;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_IDX_WIDTH:  r_width  <= i_cfg_data;
                    CFG_IDX_HEIGHT: r_height <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Segment datapath
    always_ff @(posedge i_clk) begin
        // capture a load, endpoints ordered so that y rises
        if (r_state == S_IDLE && in_acc && s_axis_tuser == REQ_LOAD) begin
            r_sx        <= sw_sx;
            r_sy        <= sw_sy;
            r_ex        <= sw_ex;
            r_ey        <= sw_ey;
            r_neg       <= sw_ex < sw_sx;
            r_rise_zero <= in_rise == '0;
        end
        if (r_state == S_SLOPE)
            r_slope <= r_neg ? (~slope_mag + ACC_W'(1)) : slope_mag;
        // start pixel: seed accumulator one row on
        if (r_state == S_START && out_free) begin
            r_acc <= (ACC_W'(r_sx) <<< ACC_SH) + r_slope;
            r_row <= round_coord(r_sy) + ROW_W'(1);
        end
        // interior row: latch split, advance
        if (r_state == S_SPLIT && below) begin
            r_px0 <= PIX_W'(ip);
            r_px1 <= PIX_W'(ip1);
            r_py  <= PIX_W'(r_row);
            r_lo  <= prod[PROD_W-1:SLOPE_FRAC_BITS];
            r_hi  <= INT_FULL - ceil_v;
            r_ok1 <= ok1;
            r_acc <= r_acc + r_slope;
            r_row <= r_row + ROW_W'(1);
        end
        // output beat
        if (emit) begin
            r_out_px   <= e_px;
            r_out_py   <= e_py;
            r_out_int  <= e_int;
            r_out_done <= e_done;
            r_out_last <= e_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_int, r_out_py, r_out_px};
    assign m_axis_tuser  = r_out_done;
    assign m_axis_tlast  = r_out_last;
    assign o_cfg_ready   = 1'b1;

endmodule

`default_nettype wire

>>> hw/rtl/aslr_checker.sv
`default_nettype none

`include "antialiased_steep_line_raster_assert.svh"

// Port-level checks on the rasteriser
module aslr_checker import aslr_pkg::*; (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   s_axis_tvalid,
    input  wire logic                   s_axis_tready,
    input  wire logic                   s_axis_tuser,
    input  wire logic                   m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    input  wire logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  wire logic                   m_axis_tuser,
    input  wire logic                   m_axis_tlast
);

    logic load_beat, end_beat, out_stall;

    assign load_beat = s_axis_tvalid && s_axis_tready && (s_axis_tuser == REQ_LOAD);
    assign end_beat  = m_axis_tvalid && m_axis_tuser;
    assign out_stall = m_axis_tvalid && !m_axis_tready;

    // a stalled result beat holds
    `ASLR_ASSERT_NEXT(a_out_hold, out_stall, m_axis_tvalid && $stable(m_axis_tdata))

    // a load keeps the input closed while the slope is formed
    `ASLR_ASSERT_NEXT(a_load_busy, load_beat, !s_axis_tready)

    // the end pixel is full intensity and closes its item
    `ASLR_ASSERT_NOW(a_end_pixel, end_beat,
        m_axis_tlast && (m_axis_tdata[OUT_TDATA_W-1 -: INT_W] == INT_FULL))

    // reset empties the output register
    `ASLR_ASSERT_RST(a_rst_out, !i_rst_n, !m_axis_tvalid)

endmodule

bind antialiased_steep_line_raster aslr_checker u_checker (.*);

`default_nettype wire
